@@ hdl/lsac_pkg.sv @@
`default_nettype none

package lsac_pkg;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 16;
  localparam int TAG_LSB = 16;
  localparam int COUNT_W = 32;

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

endpackage

`default_nettype wire

@@ hdl/lsac_ram.sv @@
`default_nettype none

module lsac_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/lru_set_assoc_cache_tags.sv @@
// an item passes registers a, b, c and s1, then the output register; one item per
// cycle unless out_stall or the clearing pass holds it; the set index comes from a
// two-stage reciprocal multiply, then one tag RAM read and a read-modify-write,
// with the previous write forwarded when consecutive items hit the same set
// reset: synchronous; counters clear to zero and a clearing pass then zeroes the
// valid bits of all SET_COUNT sets, one per cycle, with in_stall held high
`default_nettype none

module lru_set_assoc_cache_tags
  import lsac_pkg::*;
#(
  parameter int SET_COUNT   = 16384,
  parameter int WAY_COUNT   = 4,
  parameter int OFFSET_BITS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ADDR_W-1:0] address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   hit,
  output count_t                 hit_total,
  output count_t                 miss_total
);

  localparam int V_W   = ADDR_W - OFFSET_BITS;
  localparam int SET_W = $clog2(SET_COUNT);
  localparam int ROW_W = WAY_COUNT * (TAG_W + 1);
  localparam logic [63:0]    RECIP_64 = (64'd1 << V_W) / 64'(SET_COUNT);
  localparam logic [V_W-1:0] RECIP    = RECIP_64[V_W-1:0];
  localparam logic [SET_W:0] SET_N    = (SET_W+1)'(SET_COUNT);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

  typedef logic [WAY_COUNT-1:0][TAG_W-1:0] row_tags_t;
  typedef logic [WAY_COUNT-1:0]            row_valid_t;

  // clearing pass
  logic             clearing;
  logic [SET_W-1:0] clr_cnt;

  logic advance;
  logic in_accept;

  // index pipeline
  logic           a_valid;
  logic [V_W-1:0] a_v;
  tag_t           a_tag;
  logic           b_valid;
  logic [V_W-1:0] b_q;
  logic [SET_W:0] b_v_lo;
  tag_t           b_tag;
  logic           c_valid;
  logic [SET_W:0] c_r0;
  tag_t           c_tag;

  logic [2*V_W-1:0] mul_full;
  logic [SET_W:0]   prod_lo;
  logic [SET_W:0]   r_sub;
  logic [SET_W-1:0] set_idx;

  // lookup stage
  logic             s1_valid;
  logic [SET_W-1:0] s1_set;
  tag_t             s1_tag;

  logic             fwd_flag;
  logic [SET_W-1:0] fwd_set;
  logic [ROW_W-1:0] fwd_data;

  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_word;
  row_tags_t        row_tags;
  row_valid_t       row_valid;
  row_tags_t        tags_up;
  row_valid_t       valid_up;
  row_valid_t       valid_prev;
  row_valid_t       match;
  row_valid_t       at_or_after;
  row_valid_t       first_free;
  row_tags_t        new_tags;
  row_valid_t       new_valid;
  logic [ROW_W-1:0] new_word;
  logic             is_hit;
  logic             acc;

  logic             s1_write;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  count_t hit_total_next;
  count_t miss_total_next;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = clearing || !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == SET_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mul_full = {{V_W{1'b0}}, a_v} * {{V_W{1'b0}}, RECIP};
  assign prod_lo  = (SET_W+1)'(b_q[SET_W:0] * SET_N);
  assign r_sub    = c_r0 - SET_N;
  assign set_idx  = (c_r0 >= SET_N) ? r_sub[SET_W-1:0] : c_r0[SET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      s1_valid <= 1'b0;
      fwd_flag <= 1'b0;
    end else if (advance) begin
      a_valid  <= in_accept;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      s1_valid <= c_valid;
      fwd_flag <= s1_write;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_v      <= address[ADDR_W-1:OFFSET_BITS];
      a_tag    <= address[TAG_LSB +: TAG_W];
      b_q      <= mul_full[2*V_W-1:V_W];
      b_v_lo   <= a_v[SET_W:0];
      b_tag    <= a_tag;
      c_r0     <= b_v_lo - prod_lo;
      c_tag    <= b_tag;
      s1_set   <= set_idx;
      s1_tag   <= c_tag;
      fwd_set  <= s1_set;
      fwd_data <= new_word;
    end
  end

  assign row_word  = (fwd_flag && fwd_set == s1_set) ? fwd_data : ram_rdata;
  assign row_tags  = row_word[WAY_COUNT*TAG_W-1:0];
  assign row_valid = row_word[ROW_W-1 -: WAY_COUNT];

  assign tags_up    = {s1_tag, row_tags[WAY_COUNT-1:1]};
  assign valid_up   = {1'b0, row_valid[WAY_COUNT-1:1]};
  assign valid_prev = {row_valid[WAY_COUNT-2:0], 1'b1};

  always_comb begin
    acc = 1'b0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      match[w]       = row_valid[w] && (row_tags[w] == s1_tag);
      acc            = acc | match[w];
      at_or_after[w] = acc;
      first_free[w]  = !row_valid[w] && valid_prev[w];
    end
    is_hit = |match;
  end

  always_comb begin
    new_tags  = row_tags;
    new_valid = row_valid;
    if (is_hit) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (at_or_after[w]) begin
          if (valid_up[w]) begin
            new_tags[w] = tags_up[w];
          end else if (row_valid[w]) begin
            new_tags[w] = s1_tag;
          end
        end
      end
    end else if (row_valid[WAY_COUNT-1]) begin
      new_tags = tags_up;
    end else begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (first_free[w]) begin
          new_tags[w] = s1_tag;
        end
      end
      new_valid = row_valid | first_free;
    end
  end

  assign new_word = {new_valid, new_tags};

  assign s1_write  = s1_valid && advance;
  assign ram_we    = clearing || s1_write;
  assign ram_waddr = clearing ? clr_cnt : s1_set;
  assign ram_wdata = clearing ? '0 : new_word;

  lsac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (c_valid && advance),
    .raddr (set_idx),
    .rdata (ram_rdata)
  );

  assign hit_total_next  = (hit_total == COUNT_MAX) ? hit_total : hit_total + 1'b1;
  assign miss_total_next = (miss_total == COUNT_MAX) ? miss_total : miss_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        if (is_hit) begin
          hit_total <= hit_total_next;
        end else begin
          miss_total <= miss_total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit <= is_hit;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lsac_checker.sv @@
`default_nettype none

module lsac_checker
  import lsac_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   in_valid,
  input wire logic   in_stall,
  input wire logic   out_valid,
  input wire logic   out_stall,
  input wire logic   hit,
  input wire count_t hit_total,
  input wire count_t miss_total
);

  // valid bits are being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_total)
      && $stable(miss_total))
    else $error("stalled result changed");

  a_counts_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid
      || (hit_total >= $past(hit_total) && miss_total >= $past(miss_total)))
    else $error("running count went down");

  a_count_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit && hit_total != '0) || (!hit && miss_total != '0))
    else $error("count does not cover the shown item");

  a_no_accept_while_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall && !out_valid |=> !out_valid)
    else $error("result appeared from a stalled input");

endmodule

bind lru_set_assoc_cache_tags lsac_checker u_lsac_checker (.*);

`default_nettype wire
